// File: rtl/core/snrf_pkg.sv
// Shared types and constants for the serial co-processor response framer.
// No dependencies; compiled first.
package snrf_pkg;

   localparam int CntW  = 9;
   localparam int WaitW = 10;
   localparam int ByteW = 8;

   // Transaction phase codes.
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_WAIT = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_RECV = 3'd4;

   // Request codes.
   localparam logic [1:0] REQ_OPEN  = 2'd0;
   localparam logic [1:0] REQ_TX    = 2'd1;
   localparam logic [1:0] REQ_CLOCK = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_WAIT_LIMIT  = 1'b0;
   localparam logic CSR_RX_CAPACITY = 1'b1;

   // Response classes.
   localparam logic [2:0] CLS_FRAME     = 3'd0;
   localparam logic [2:0] CLS_VERSION   = 3'd1;
   localparam logic [2:0] CLS_NOT_READY = 3'd2;
   localparam logic [2:0] CLS_READY     = 3'd3;
   localparam logic [2:0] CLS_ERROR     = 3'd4;
   localparam logic [2:0] CLS_UNKNOWN   = 3'd5;
   localparam logic [2:0] CLS_NONE      = 3'd6;

   localparam logic [ByteW-1:0] IDLE_BYTE  = 8'hFF;
   localparam logic [ByteW-1:0] FRAME_BYTE = 8'hFE;
   localparam logic [ByteW-1:0] TERM_BYTE  = 8'hA7;
   localparam logic [ByteW-1:0] MAX_ERROR  = 8'h04;

   typedef struct packed {
      logic             cs_asserted;
      logic [ByteW-1:0] mosi_byte;
      logic             clock_more;
      logic             store_valid;
      logic [CntW-1:0]  store_index;
      logic [ByteW-1:0] store_byte;
      logic             done_res;
      logic [CntW-1:0]  resp_length;
      logic [2:0]       resp_class;
      logic             ends_on_terminator;
   } rsp_payload_type;

   function automatic logic [2:0] class_of(input logic [ByteW-1:0] b);
      logic [2:0] c;
      if (b == FRAME_BYTE) begin
         c = CLS_FRAME;
      end else if ((b & 8'hC0) == 8'h80) begin
         c = CLS_VERSION;
      end else if ((b & 8'hFE) == 8'hC0) begin
         c = b[0] ? CLS_READY : CLS_NOT_READY;
      end else if (b <= MAX_ERROR) begin
         c = CLS_ERROR;
      end else begin
         c = CLS_UNKNOWN;
      end
      return c;
   endfunction

endpackage

// File: rtl/core/snrf_req_if.sv
// Request channel of the response framer: valid/ready plus one request word.
// Depends on snrf_pkg.
interface snrf_req_if import snrf_pkg::*;;
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [ByteW-1:0] tx_byte;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output req_type, output tx_byte, output rx_byte,
                   input ready);
   modport sink (input valid, input req_type, input tx_byte, input rx_byte,
                 output ready);
endinterface

// File: rtl/core/snrf_rsp_if.sv
// Result channel of the response framer: valid/ready plus one result word.
// Depends on snrf_pkg.
interface snrf_rsp_if import snrf_pkg::*;;
   logic             valid;
   logic             ready;
   logic             cs_asserted;
   logic [ByteW-1:0] mosi_byte;
   logic             clock_more;
   logic             store_valid;
   logic [CntW-1:0]  store_index;
   logic [ByteW-1:0] store_byte;
   logic             done_res;
   logic [CntW-1:0]  resp_length;
   logic [2:0]       resp_class;
   logic             ends_on_terminator;

   modport source (output valid, output cs_asserted, output mosi_byte,
                   output clock_more, output store_valid, output store_index,
                   output store_byte, output done_res, output resp_length,
                   output resp_class, output ends_on_terminator, input ready);
   modport sink (input valid, input cs_asserted, input mosi_byte,
                 input clock_more, input store_valid, input store_index,
                 input store_byte, input done_res, input resp_length,
                 input resp_class, input ends_on_terminator, output ready);
endinterface

// File: rtl/core/spi_ncp_response_framer.sv
// Host-side transaction framer for a serial co-processor link.
// A request word is registered in the input stage, and its result word then in the output register.
// One word per cycle while the result channel is ready; the transaction state updates in a single pass.
// The input stage takes a new word while a finished result waits in the output register.
// Synchronous active-high reset clears state and loads register defaults.
// Depends on snrf_pkg, snrf_req_if and snrf_rsp_if.
module spi_ncp_response_framer import snrf_pkg::*; #(
   parameter int PAD_LIMIT = 260
) (
   input  logic              clock,
   input  logic              reset,
   snrf_req_if.sink          req_ch,
   snrf_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [WaitW-1:0]  csr_wdata
);

   localparam int PadW = $clog2(PAD_LIMIT + 1);
   localparam int CmpW = (PadW > CntW) ? PadW : CntW;

   // Configuration registers.
   logic [WaitW-1:0] wait_limit_ff;
   logic [CntW-1:0]  rx_capacity_ff;

   // Input stage.
   logic             in_valid_ff;
   logic [1:0]       req_type_ff;
   logic [ByteW-1:0] tx_byte_ff;
   logic [ByteW-1:0] rx_byte_ff;

   // Transaction state.
   logic [2:0]       phase_ff, phase_in;
   logic [WaitW-1:0] wait_count_ff, wait_count_in;
   logic [CntW-1:0]  stored_count_ff, stored_count_in;
   logic [CntW-1:0]  remaining_ff, remaining_in;
   logic [ByteW-1:0] first_byte_ff, first_byte_in;
   logic [ByteW-1:0] last_byte_ff, last_byte_in;

   // Output stage.
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type res_ff, res_in;

   logic advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ch.ready);

   always_comb begin
      logic             take_remain;
      logic [CntW-1:0]  remain;
      logic             finish;
      logic             with_resp;
      logic [CntW-1:0]  cap;
      logic [CntW-1:0]  room;
      logic [CntW-1:0]  rem_c;
      logic [CmpW-1:0]  rem_w;

      take_remain     = 1'b0;
      remain          = '0;
      finish          = 1'b0;
      with_resp       = 1'b0;
      phase_in        = phase_ff;
      wait_count_in   = wait_count_ff;
      stored_count_in = stored_count_ff;
      remaining_in    = remaining_ff;
      first_byte_in   = first_byte_ff;
      last_byte_in    = last_byte_ff;
      cap             = (rx_capacity_ff == '0) ? CntW'(1) : rx_capacity_ff;

      res_in                    = '0;
      res_in.mosi_byte          = IDLE_BYTE;
      res_in.resp_class         = CLS_NONE;

      unique case (req_type_ff)
         REQ_OPEN: begin
            phase_in        = PH_CMD;
            wait_count_in   = '0;
            stored_count_in = '0;
            remaining_in    = '0;
            first_byte_in   = IDLE_BYTE;
            last_byte_in    = '0;
         end
         REQ_TX: begin
            if (phase_ff == PH_CMD) begin
               res_in.mosi_byte = tx_byte_ff;
            end
         end
         REQ_CLOCK: begin
            if (phase_ff == PH_CMD || phase_ff == PH_WAIT) begin
               phase_in = PH_WAIT;
               if (wait_count_ff >= wait_limit_ff) begin
                  finish = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff + WaitW'(1);
                  if (rx_byte_ff == IDLE_BYTE) begin
                     finish = (wait_count_in >= wait_limit_ff);
                  end else begin
                     first_byte_in      = rx_byte_ff;
                     res_in.store_valid = 1'b1;
                     res_in.store_index = stored_count_ff;
                     res_in.store_byte  = rx_byte_ff;
                     last_byte_in       = rx_byte_ff;
                     stored_count_in    = stored_count_ff + CntW'(1);
                     take_remain        = 1'b1;
                     if (rx_byte_ff == FRAME_BYTE) begin
                        remain = CntW'(1);
                        if (stored_count_in < cap) begin
                           phase_in    = PH_LEN;
                           take_remain = 1'b0;
                        end
                     end else if (rx_byte_ff <= MAX_ERROR) begin
                        remain = CntW'(2);
                     end else begin
                        remain = CntW'(1);
                     end
                  end
               end
            end else if (phase_ff == PH_LEN || phase_ff == PH_RECV) begin
               res_in.store_valid = 1'b1;
               res_in.store_index = stored_count_ff;
               res_in.store_byte  = rx_byte_ff;
               last_byte_in       = rx_byte_ff;
               stored_count_in    = stored_count_ff + CntW'(1);
               if (phase_ff == PH_LEN) begin
                  take_remain = 1'b1;
                  remain      = {1'b0, rx_byte_ff} + CntW'(1);
               end else begin
                  remaining_in = (remaining_ff != '0) ? remaining_ff - CntW'(1) : '0;
                  if (remaining_in == '0) begin
                     finish    = 1'b1;
                     with_resp = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // Clamp to the free buffer room and the pad limit.
      room  = (cap > stored_count_in) ? cap - stored_count_in : '0;
      rem_c = (remain > room) ? room : remain;
      rem_w = CmpW'(rem_c);
      if (rem_w > CmpW'(PAD_LIMIT)) begin
         rem_w = CmpW'(PAD_LIMIT);
      end
      if (take_remain) begin
         remaining_in = rem_w[CntW-1:0];
         if (remaining_in == '0) begin
            finish    = 1'b1;
            with_resp = 1'b1;
         end else begin
            phase_in = PH_RECV;
         end
      end

      if (finish) begin
         phase_in        = PH_IDLE;
         res_in.done_res = 1'b1;
         if (with_resp) begin
            res_in.resp_length        = stored_count_in;
            res_in.resp_class         = class_of(first_byte_in);
            res_in.ends_on_terminator = (last_byte_in == TERM_BYTE);
         end
      end

      res_in.cs_asserted = (phase_in != PH_IDLE);
      if (phase_in == PH_CMD || phase_in == PH_WAIT) begin
         res_in.clock_more = (wait_count_in < wait_limit_ff);
      end else if (phase_in == PH_LEN || phase_in == PH_RECV) begin
         res_in.clock_more = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_limit_ff   <= WaitW'(64);
         rx_capacity_ff  <= CntW'(260);
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         wait_count_ff   <= '0;
         stored_count_ff <= '0;
         remaining_ff    <= '0;
         first_byte_ff   <= IDLE_BYTE;
         last_byte_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WAIT_LIMIT:  wait_limit_ff  <= csr_wdata;
               CSR_RX_CAPACITY: rx_capacity_ff <= csr_wdata[CntW-1:0];
               default: begin
               end
            endcase
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            wait_count_ff   <= wait_count_in;
            stored_count_ff <= stored_count_in;
            remaining_ff    <= remaining_in;
            first_byte_ff   <= first_byte_in;
            last_byte_ff    <= last_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_type_ff <= req_ch.req_type;
         tx_byte_ff  <= req_ch.tx_byte;
         rx_byte_ff  <= req_ch.rx_byte;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.cs_asserted        = res_ff.cs_asserted;
   assign rsp_ch.mosi_byte          = res_ff.mosi_byte;
   assign rsp_ch.clock_more         = res_ff.clock_more;
   assign rsp_ch.store_valid        = res_ff.store_valid;
   assign rsp_ch.store_index        = res_ff.store_index;
   assign rsp_ch.store_byte         = res_ff.store_byte;
   assign rsp_ch.done_res           = res_ff.done_res;
   assign rsp_ch.resp_length        = res_ff.resp_length;
   assign rsp_ch.resp_class         = res_ff.resp_class;
   assign rsp_ch.ends_on_terminator = res_ff.ends_on_terminator;

   // A finished transaction must have released chip select.
   a_done_releases_cs: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.done_res) |-> (!res_ff.cs_asserted && !res_ff.clock_more))
      else $error("done word with chip select still asserted");

   // A response class is only reported on the closing word.
   a_class_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.resp_class != CLS_NONE) |-> res_ff.done_res)
      else $error("response class reported before the transaction ended");

   // Unstored words carry a zero store position and data.
   a_store_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !res_ff.store_valid) |->
         (res_ff.store_index == '0 && res_ff.store_byte == '0))
      else $error("store fields set on a word that stores nothing");

   // A full pipeline with a stalled result must not take another word.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while both stages are full and stalled");

   // Each processed word lands in the output register.
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed word did not reach the output register");

endmodule

// File: verif/spi_ncp_response_framer_test.sv
// Self-checking testbench for spi_ncp_response_framer: drives request words,
// predicts every result word and compares it field by field.
// Depends on snrf_pkg, snrf_req_if, snrf_rsp_if and the framer RTL.
`timescale 1ns / 100ps

module spi_ncp_response_framer_test import snrf_pkg::*;;

   localparam int          PAD_LIMIT   = 260;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned SETTLE      = 4;
   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ByteW-1:0] tx;
      logic [ByteW-1:0] rx;
   } link_word_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [WaitW-1:0] csr_wdata;

   snrf_req_if req_ch ();
   snrf_rsp_if rsp_ch ();

   spi_ncp_response_framer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted framer state and register copies.
   logic [2:0]       ph = PH_IDLE;
   logic [WaitW-1:0] waited = '0;
   logic [CntW-1:0]  stored = '0;
   logic [CntW-1:0]  remaining = '0;
   logic [ByteW-1:0] first_byte = IDLE_BYTE;
   logic [ByteW-1:0] last_byte = '0;
   logic [WaitW-1:0] wait_limit;
   logic [CntW-1:0]  rx_cap;

   link_word_type   pending_words[$];
   rsp_payload_type pending_results[$];
   link_word_type   offered;
   rsp_payload_type due;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_armed = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned cycle_count = 0;
   int unsigned words_queued = 0;
   int unsigned words_sent = 0;
   int unsigned results_checked = 0;
   int unsigned closed_count = 0;
   int unsigned answered_count = 0;
   int unsigned settings_used = 1;
   int unsigned mismatches = 0;

   function automatic logic [2:0] response_class(input logic [ByteW-1:0] b);
      if (b == FRAME_BYTE) return CLS_FRAME;
      if (b[7:6] == 2'b10) return CLS_VERSION;
      if (b[7:1] == 7'h60) return b[0] ? CLS_READY : CLS_NOT_READY;
      if (b <= MAX_ERROR) return CLS_ERROR;
      return CLS_UNKNOWN;
   endfunction

   function automatic void close_transaction(inout rsp_payload_type r,
                                             input bit with_response);
      r.done_res = 1'b1;
      if (with_response) begin
         r.resp_length        = stored;
         r.resp_class         = response_class(first_byte);
         r.ends_on_terminator = (last_byte == TERM_BYTE);
      end
      ph = PH_IDLE;
   endfunction

   function automatic void keep_byte(inout rsp_payload_type r, input logic [ByteW-1:0] b);
      r.store_valid = 1'b1;
      r.store_index = stored;
      r.store_byte  = b;
      last_byte     = b;
      stored        = stored + CntW'(1);
   endfunction

   // Clamp the bytes still to come to the free room, then finish or keep receiving.
   function automatic void clamp_remaining(inout rsp_payload_type r, input int unsigned want);
      int unsigned cap;
      int unsigned room;
      int unsigned n;
      cap  = (rx_cap == '0) ? 1 : 32'(rx_cap);
      room = (cap > 32'(stored)) ? cap - 32'(stored) : 0;
      n    = (want < room) ? want : room;
      if (n > PAD_LIMIT) n = PAD_LIMIT;
      remaining = n[CntW-1:0];
      if (remaining == '0) begin
         close_transaction(r, 1'b1);
      end else begin
         ph = PH_RECV;
      end
   endfunction

   function automatic rsp_payload_type framer_result(input link_word_type w);
      rsp_payload_type r;
      int unsigned     cap;
      r            = '0;
      r.mosi_byte  = IDLE_BYTE;
      r.resp_class = CLS_NONE;
      cap          = (rx_cap == '0) ? 1 : 32'(rx_cap);
      case (w.kind)
         REQ_OPEN: begin
            ph         = PH_CMD;
            waited     = '0;
            stored     = '0;
            remaining  = '0;
            first_byte = IDLE_BYTE;
            last_byte  = '0;
         end
         REQ_TX: begin
            if (ph == PH_CMD) r.mosi_byte = w.tx;
         end
         REQ_CLOCK: begin
            case (ph)
               PH_CMD, PH_WAIT: begin
                  ph = PH_WAIT;
                  if (waited >= wait_limit) begin
                     close_transaction(r, 1'b0);
                  end else begin
                     waited = waited + WaitW'(1);
                     if (w.rx == IDLE_BYTE) begin
                        if (waited >= wait_limit) close_transaction(r, 1'b0);
                     end else begin
                        first_byte = w.rx;
                        keep_byte(r, w.rx);
                        if (w.rx == FRAME_BYTE) begin
                           // A frame needs room for its length byte first.
                           if (32'(stored) < cap) ph = PH_LEN;
                           else clamp_remaining(r, 1);
                        end else if (w.rx <= MAX_ERROR) begin
                           clamp_remaining(r, 2);
                        end else begin
                           clamp_remaining(r, 1);
                        end
                     end
                  end
               end
               PH_LEN: begin
                  keep_byte(r, w.rx);
                  clamp_remaining(r, 32'(w.rx) + 1);
               end
               PH_RECV: begin
                  keep_byte(r, w.rx);
                  if (remaining != '0) remaining = remaining - CntW'(1);
                  if (remaining == '0) close_transaction(r, 1'b1);
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      r.cs_asserted = (ph != PH_IDLE);
      if (ph == PH_CMD || ph == PH_WAIT) begin
         r.clock_more = (waited < wait_limit);
      end else if (ph == PH_LEN || ph == PH_RECV) begin
         r.clock_more = 1'b1;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding",
                  pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Request driver: predicts on every accepted word, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(framer_result(offered));
            words_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = pending_words.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.req_type <= offered.kind;
               req_ch.tx_byte  <= offered.tx;
               req_ch.rx_byte  <= offered.rx;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_armed && hold_cycles < LONG_HOLD) hold_cycles <= hold_cycles + 1;
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("Result word arrived with nothing expected");
               mismatches++;
            end else begin
               due = pending_results.pop_front();
               check_field("cs_asserted", 16'(due.cs_asserted), 16'(rsp_ch.cs_asserted));
               check_field("mosi_byte", 16'(due.mosi_byte), 16'(rsp_ch.mosi_byte));
               check_field("clock_more", 16'(due.clock_more), 16'(rsp_ch.clock_more));
               check_field("store_valid", 16'(due.store_valid), 16'(rsp_ch.store_valid));
               check_field("store_index", 16'(due.store_index), 16'(rsp_ch.store_index));
               check_field("store_byte", 16'(due.store_byte), 16'(rsp_ch.store_byte));
               check_field("done_res", 16'(due.done_res), 16'(rsp_ch.done_res));
               check_field("resp_length", 16'(due.resp_length), 16'(rsp_ch.resp_length));
               check_field("resp_class", 16'(due.resp_class), 16'(rsp_ch.resp_class));
               check_field("ends_on_terminator", 16'(due.ends_on_terminator),
                           16'(rsp_ch.ends_on_terminator));
               results_checked++;
               if (due.done_res) closed_count++;
               if (due.done_res && due.resp_class != CLS_NONE) answered_count++;
            end
         end
         rsp_ch.ready <= !(hold_armed && hold_cycles < LONG_HOLD) &&
                         ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_word(input logic [1:0] kind, input logic [ByteW-1:0] tx,
                            input logic [ByteW-1:0] rx);
      link_word_type w;
      w.kind = kind;
      w.tx   = tx;
      w.rx   = rx;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // One transaction: open, commands, idle bytes, then a response of random shape.
   task automatic queue_transaction();
      int unsigned      n_idle;
      int unsigned      n_more;
      int unsigned      long_wait;
      int unsigned      len;
      int unsigned      k;
      logic [ByteW-1:0] lead;
      push_word(REQ_OPEN, 8'($urandom), 8'($urandom));
      repeat ($urandom_range(0, 4)) push_word(REQ_TX, 8'($urandom), 8'($urandom));
      long_wait = (wait_limit < WaitW'(40)) ? 32'(wait_limit) + 2 : 40;
      n_idle = ($urandom_range(0, 7) == 0) ? $urandom_range(0, long_wait)
                                          : $urandom_range(0, 2);
      repeat (n_idle) begin
         push_word(REQ_CLOCK, 8'($urandom), IDLE_BYTE);
         if ($urandom_range(0, 19) == 0) push_word(REQ_TX, 8'($urandom), 8'($urandom));
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: lead = FRAME_BYTE;
         4:          lead = {2'b10, 6'($urandom)};
         5:          lead = {7'h60, 1'($urandom)};
         6, 7:       lead = 8'($urandom_range(0, MAX_ERROR));
         default:    lead = 8'($urandom);
      endcase
      push_word(REQ_CLOCK, 8'($urandom), lead);
      if (lead == FRAME_BYTE) begin
         // Long frames are rare; they dominate the run time otherwise.
         len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
         push_word(REQ_CLOCK, 8'($urandom), 8'(len));
         n_more = len + 1;
      end else if (lead <= MAX_ERROR) begin
         n_more = 2;
      end else begin
         n_more = 1;
      end
      if ($urandom_range(0, 11) == 0) n_more = $urandom_range(0, n_more - 1);
      for (k = 1; k <= n_more; k++) begin
         push_word(REQ_CLOCK, 8'($urandom),
                   (k == n_more && $urandom_range(0, 4) != 0) ? TERM_BYTE : 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) push_word(REQ_CLOCK, 8'($urandom), 8'($urandom));
   endtask

   task automatic fill(input int unsigned n);
      int unsigned goal;
      goal = words_queued + n;
      while (words_queued < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            push_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end else begin
            queue_transaction();
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_ch.valid || pending_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [WaitW-1:0] wl, input logic [CntW-1:0] cap,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned n);
      wait_drained();
      @(posedge clock);
      csr_we     <= 1'b1;
      csr_index  <= CSR_WAIT_LIMIT;
      csr_wdata  <= wl;
      wait_limit = wl;
      @(posedge clock);
      csr_index  <= CSR_RX_CAPACITY;
      csr_wdata  <= {1'b0, cap};
      rx_cap     = cap;
      @(posedge clock);
      csr_we     <= 1'b0;
      settings_used++;
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      fill(n);
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_WAIT_LIMIT;
      csr_wdata        = '0;
      wait_limit       = 10'd64;
      rx_cap           = 9'd260;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at the reset register values.
      push_word(REQ_CLOCK, 8'h00, 8'h00);   // clocked while idle
      push_word(REQ_TX, 8'hFF, 8'hFF);      // command while idle
      push_word(REQ_UNUSED, 8'hFF, 8'hFF);
      push_word(REQ_OPEN, 8'h00, 8'h00);
      push_word(REQ_TX, 8'h00, 8'h00);
      push_word(REQ_TX, 8'hFF, 8'h00);
      push_word(REQ_CLOCK, 8'h00, IDLE_BYTE);
      push_word(REQ_CLOCK, 8'h00, FRAME_BYTE);
      push_word(REQ_CLOCK, 8'h00, 8'h00);   // zero length still means one more byte
      push_word(REQ_CLOCK, 8'h00, TERM_BYTE);
      push_word(REQ_TX, 8'h5A, 8'h00);      // command after the transaction ended
      push_word(REQ_OPEN, 8'h00, 8'h00);
      push_word(REQ_CLOCK, 8'h00, 8'h03);   // error code straight after the open
      push_word(REQ_OPEN, 8'hFF, 8'hFF);    // reopen drops the running transaction
      push_word(REQ_CLOCK, 8'h00, 8'hC1);
      push_word(REQ_CLOCK, 8'h00, TERM_BYTE);
      push_word(REQ_OPEN, 8'h00, 8'h00);
      push_word(REQ_CLOCK, 8'h00, 8'hC0);
      push_word(REQ_CLOCK, 8'h00, 8'h00);   // ends away from the terminator
      push_word(REQ_OPEN, 8'h00, 8'h00);
      push_word(REQ_CLOCK, 8'h00, 8'h80);
      push_word(REQ_CLOCK, 8'h00, TERM_BYTE);
      push_word(REQ_OPEN, 8'h00, 8'h00);
      push_word(REQ_CLOCK, 8'h00, 8'h05);
      push_word(REQ_CLOCK, 8'h00, TERM_BYTE);

      run_phase(10'd64, 9'd260, 0, 0, 300);
      run_phase(10'd3, 9'd260, 85, 0, 200);
      run_phase(10'd0, 9'd260, 0, 85, 60);
      // Receiver holds off for a long stretch while words keep coming.
      run_phase(10'd1023, 9'd260, 0, 0, 250);
      hold_armed <= 1'b1;
      run_phase(10'd10, 9'd1, 0, 0, 80);
      run_phase(10'd5, 9'd0, 18, 18, 60);
      run_phase(10'd20, 9'd5, 85, 0, 120);
      run_phase(10'd2, 9'd40, 0, 85, 200);
      run_phase(10'($urandom_range(1, 30)), 9'($urandom_range(1, 260)), 18, 18, 125);
      // The sender pauses here until every outstanding result is back.
      wait_drained();
      @(negedge clock);
      fill(125);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d request words under %0d register settings; %0d result words checked.",
               words_sent, settings_used, results_checked);
      $display("%0d transactions closed, %0d of them with a response.",
               closed_count, answered_count);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
